// ===== sv/i2f_pkg.sv =====
package i2f_pkg;

	localparam int unsigned INT_W     = 32;
	localparam int unsigned FRAC_BITS = 23;
	localparam int unsigned DROP_BITS = INT_W - (FRAC_BITS + 1);
	localparam int unsigned LZ_W      = 5;

	localparam logic [7:0] EXP_BASE = 8'd158;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic              sign;
		logic              zero;
		logic [INT_W-1:0]  mag;
		logic [LZ_W-1:0]   lz;
	} front_item_t;

endpackage

// ===== sv/int32_to_float32_convert_core.sv =====
// Converts a signed 32-bit integer to the bit pattern of the equal IEEE 754
// single-precision value, rounding to nearest with ties to even. One item is
// accepted per clock cycle while the output is not stalled. An item that finds
// the block empty passes the front register, a queue entry and the output
// register, in that order, before its result is on the outputs. The front
// stage takes the sign, magnitude and leading-zero count combinationally, and
// the back stage does the normalizing shift and the rounding add, also
// combinationally. A queue of QUEUE_DEPTH items between them lets the front
// keep taking items while the output is stalled, until the queue is full.
module int32_to_float32_convert_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] int_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        float_bits
);

	logic                  f_valid;
	logic                  f_ready;
	i2f_pkg::front_item_t  f_item;
	logic                  b_valid;
	logic                  b_ready;
	i2f_pkg::front_item_t  b_item;

	i2f_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.int_value  (int_value),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	i2f_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	i2f_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.float_bits (float_bits)
	);

endmodule

// ===== sv/i2f_front.sv =====
module i2f_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [31:0]       int_value,
	output logic                     item_valid,
	input  logic                     item_ready,
	output i2f_pkg::front_item_t     item
);

	function automatic logic [i2f_pkg::LZ_W-1:0] count_lz(input logic [31:0] v);
		logic [31:0]                 x;
		logic [i2f_pkg::LZ_W-1:0]    n;
		x = v;
		n = '0;
		if (x[31:16] == 16'd0) begin
			n[4] = 1'b1;
			x    = {x[15:0], 16'd0};
		end
		if (x[31:24] == 8'd0) begin
			n[3] = 1'b1;
			x    = {x[23:0], 8'd0};
		end
		if (x[31:28] == 4'd0) begin
			n[2] = 1'b1;
			x    = {x[27:0], 4'd0};
		end
		if (x[31:30] == 2'd0) begin
			n[1] = 1'b1;
			x    = {x[29:0], 2'd0};
		end
		if (x[31] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

	logic                  valid_s1;
	i2f_pkg::front_item_t  item_s1;
	i2f_pkg::front_item_t  item_d;
	logic [31:0]           raw;

	assign raw = int_value;

	always_comb begin
		item_d.sign = raw[31];
		item_d.zero = (raw == 32'd0);
		item_d.mag  = raw[31] ? (32'd0 - raw) : raw;
		item_d.lz   = count_lz(item_d.mag);
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== sv/i2f_queue.sv =====
module i2f_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  i2f_pkg::front_item_t  push_item,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output i2f_pkg::front_item_t  pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	i2f_pkg::front_item_t  entry_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");

endmodule

// ===== sv/i2f_back.sv =====
module i2f_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  i2f_pkg::front_item_t  item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           float_bits
);

	logic                                 valid_s3;
	logic [31:0]                          float_bits_s3;
	logic [31:0]                          norm;
	logic [i2f_pkg::FRAC_BITS:0]          kept;
	logic [i2f_pkg::DROP_BITS-1:0]        low;
	logic                                 round_up;
	logic [7:0]                           exp_m1;
	logic [30:0]                          body;
	logic [31:0]                          result;
	logic                                 take;

	assign norm     = item.mag << item.lz;
	assign kept     = norm[31:i2f_pkg::DROP_BITS];
	assign low      = norm[i2f_pkg::DROP_BITS-1:0];
	assign round_up = low[i2f_pkg::DROP_BITS-1]
		&& ((low[i2f_pkg::DROP_BITS-2:0] != '0) || kept[0]);
	assign exp_m1   = (i2f_pkg::EXP_BASE - 8'd1) - {3'd0, item.lz};
	assign body     = {exp_m1, {i2f_pkg::FRAC_BITS{1'b0}}}
		+ {7'd0, kept} + {30'd0, round_up};
	assign result   = item.zero ? 32'd0 : {item.sign, body};

	assign item_ready = !valid_s3 || out_ready;
	assign take       = item_valid && item_ready;
	assign out_valid  = valid_s3;
	assign float_bits = float_bits_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (item_ready) begin
			valid_s3 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			float_bits_s3 <= result;
		end
	end

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.zero) |=> (float_bits == 32'd0))
		else $error("zero item did not give zero bits");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item.zero) |=> (float_bits[30:23] <= i2f_pkg::EXP_BASE
			&& float_bits[30:23] != 8'd0))
		else $error("exponent out of range");

	a_sign_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item.zero) |=> (float_bits[31] == $past(item.sign)))
		else $error("sign bit lost");

endmodule
